@@ design/rmq_pkg.sv @@
// Shared types for the rotation-matrix-to-quaternion pipeline.
// No dependencies.
package rmq_pkg;

    // Which quaternion part is formed as S/4 (branch of Shepperd's method).
    typedef enum logic [1:0] {
        SEL_TRACE = 2'd0,
        SEL_X     = 2'd1,
        SEL_Y     = 2'd2,
        SEL_Z     = 2'd3
    } sel_t;

endpackage

@@ design/rmq_sqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
// Depends on nothing; all stages advance only while en is high.
module rmq_sqrt #(
    parameter int ROOT_W = 16
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [2*ROOT_W-1:0]   rad_in,
    output logic [ROOT_W-1:0]     root_out
);

    logic [2*ROOT_W-1:0] rad_reg  [ROOT_W+1];
    logic [ROOT_W+1:0]   rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]   root_reg [ROOT_W+1];

    assign rad_reg[0]  = rad_in;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        logic [ROOT_W+1:0] cand;
        logic [ROOT_W+1:0] trial;
        logic              ge;
        logic [ROOT_W+1:0] rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb begin
            cand      = {rem_reg[i][ROOT_W-1:0], rad_reg[i][2*ROOT_W-1 -: 2]};
            trial     = {root_reg[i], 2'b01};
            ge        = (cand >= trial);
            rem_next  = ge ? (cand - trial) : cand;
            root_next = {root_reg[i][ROOT_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[i+1]  <= {rad_reg[i][2*ROOT_W-3:0], 2'b00};
                rem_reg[i+1]  <= rem_next;
                root_reg[i+1] <= root_next;
            end
        end
    end

    assign root_out = root_reg[ROOT_W];

endmodule

@@ design/rmq_div.sv @@
// Pipelined rounded divider: q = (mag * 2^FRAC_BITS + r) / (2r), one bit a stage.
// Depends on nothing; stages advance only while en is high; ovf marks q >= 2^(DATA_WIDTH+1).
module rmq_div #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14,
    parameter int ROOT_W     = 16
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [DATA_WIDTH:0]   mag_in,
    input  logic [ROOT_W-1:0]     r_in,
    output logic [DATA_WIDTH:0]   q_out,
    output logic                  ovf_out
);

    localparam int NumW = DATA_WIDTH + FRAC_BITS + 2;
    localparam int DenW = ROOT_W + 1;
    localparam int QW   = DATA_WIDTH + 1;

    logic [NumW-1:0] num;
    logic [NumW-1:0] num_hi;
    logic [NumW-1:0] den_ext;
    logic            ovf;

    always_comb begin
        num     = {mag_in, {FRAC_BITS{1'b0}}, 1'b0} >> 1;
        num     = num + NumW'(r_in);
        num_hi  = num >> QW;
        den_ext = NumW'({r_in, 1'b0});
        ovf     = (num_hi >= den_ext);
    end

    logic [DenW-1:0] den_reg [QW+1];
    logic [DenW-1:0] rem_reg [QW+1];
    logic [QW-1:0]   lo_reg  [QW+1];
    logic [QW-1:0]   q_reg   [QW+1];
    logic            ovf_reg [QW+1];

    // front stage: overflow check and first partial remainder
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= {r_in, 1'b0};
            rem_reg[0] <= ovf ? '0 : num_hi[DenW-1:0];
            lo_reg[0]  <= num[QW-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DenW:0]   cand;
        logic [DenW:0]   diff;
        logic            ge;

        always_comb begin
            cand = {rem_reg[k], lo_reg[k][QW-1]};
            diff = cand - {1'b0, den_reg[k]};
            ge   = (cand >= {1'b0, den_reg[k]});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k+1] <= den_reg[k];
                rem_reg[k+1] <= ge ? diff[DenW-1:0] : cand[DenW-1:0];
                lo_reg[k+1]  <= {lo_reg[k][QW-2:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][QW-2:0], ge};
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign q_out   = q_reg[QW];
    assign ovf_out = ovf_reg[QW];

endmodule

@@ design/rotation_matrix_to_quaternion.sv @@
// Rotation matrix to quaternion (Shepperd's method), fixed point, deep pipeline.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
// Usage:
//   Input channel (s_valid/s_ready) carries the nine entries R[i][j] of a 3x3
//   rotation matrix, signed with FRAC_BITS fraction bits. Result channel
//   (m_valid/m_ready) carries quat_w/x/y/z in the same format plus a
//   saturated flag that is set when any part clipped or S came out zero.
//   Data passes the front register, the square root (one root bit per stage;
//   ROOT_W = (max(DATA_WIDTH,FRAC_BITS)+FRAC_BITS+3)/2, 16 at defaults),
//   then the three parallel dividers (a front register, then one quotient bit per
//   stage), and last the output register.
//   Throughput is one matrix per cycle while the receiver takes results.
//   When the receiver stalls (m_valid high, m_ready low) the whole pipeline
//   holds, s_ready drops, and nothing is dropped or repeated; the output
//   register acts as the final stage, so the input side keeps moving as long
//   as the result is taken.
//   Reset (aresetn low, synchronous) clears all valid bits; payload registers
//   are not reset.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_r00,
    input  logic signed [DATA_WIDTH-1:0] s_r01,
    input  logic signed [DATA_WIDTH-1:0] s_r02,
    input  logic signed [DATA_WIDTH-1:0] s_r10,
    input  logic signed [DATA_WIDTH-1:0] s_r11,
    input  logic signed [DATA_WIDTH-1:0] s_r12,
    input  logic signed [DATA_WIDTH-1:0] s_r20,
    input  logic signed [DATA_WIDTH-1:0] s_r21,
    input  logic signed [DATA_WIDTH-1:0] s_r22,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_quat_w,
    output logic signed [DATA_WIDTH-1:0] m_quat_x,
    output logic signed [DATA_WIDTH-1:0] m_quat_y,
    output logic signed [DATA_WIDTH-1:0] m_quat_z,
    output logic                         m_saturated
);

    localparam int MW     = (DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS;
    localparam int AW     = MW + 3;                       // signed radicand width
    localparam int ROOT_W = (MW + 2 + FRAC_BITS + 1) / 2;
    localparam int DW     = DATA_WIDTH + 1;               // numerator width
    localparam int DIV_LAT = DATA_WIDTH + 2;
    localparam int CW     = ((ROOT_W > DATA_WIDTH) ? ROOT_W : DATA_WIDTH) + 2;
    localparam int TOT_LAT = 2 + ROOT_W + DIV_LAT;

    localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Advance everything together; the output register is the last stage.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- front stage: trace, branch, radicand, numerators
    logic signed [AW-1:0] e00, e11, e22, one_s, tr, rad_s;
    logic                 m00_big, m11_big;
    rmq_pkg::sel_t        sel;
    logic signed [DW-1:0] d0, d1, d2;
    logic [MW+1:0]        a_pos;

    always_comb begin
        e00     = AW'(s_r00);
        e11     = AW'(s_r11);
        e22     = AW'(s_r22);
        one_s   = AW'(1) <<< FRAC_BITS;
        tr      = e00 + e11 + e22;
        m00_big = (s_r00 > s_r11) && (s_r00 > s_r22);
        m11_big = (s_r11 > s_r22);
        if (tr > 0) begin
            sel   = rmq_pkg::SEL_TRACE;
            rad_s = tr + one_s;
            d0    = DW'(s_r21) - DW'(s_r12);
            d1    = DW'(s_r02) - DW'(s_r20);
            d2    = DW'(s_r10) - DW'(s_r01);
        end else if (m00_big) begin
            sel   = rmq_pkg::SEL_X;
            rad_s = one_s + e00 - e11 - e22;
            d0    = DW'(s_r21) - DW'(s_r12);
            d1    = DW'(s_r01) + DW'(s_r10);
            d2    = DW'(s_r02) + DW'(s_r20);
        end else if (m11_big) begin
            sel   = rmq_pkg::SEL_Y;
            rad_s = one_s + e11 - e00 - e22;
            d0    = DW'(s_r02) - DW'(s_r20);
            d1    = DW'(s_r01) + DW'(s_r10);
            d2    = DW'(s_r12) + DW'(s_r21);
        end else begin
            sel   = rmq_pkg::SEL_Z;
            rad_s = one_s + e22 - e00 - e11;
            d0    = DW'(s_r10) - DW'(s_r01);
            d1    = DW'(s_r02) + DW'(s_r20);
            d2    = DW'(s_r12) + DW'(s_r21);
        end
        // clamp a non-positive radicand to zero
        a_pos = (rad_s > 0) ? rad_s[MW+1:0] : '0;
    end

    localparam int SIDE1_W = 2 + 3 * DW;

    logic [2*ROOT_W-1:0] rad_reg;
    logic [SIDE1_W-1:0]  side1_reg [ROOT_W+1];
    logic [TOT_LAT:1]    vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg      <= (2*ROOT_W)'({a_pos, {FRAC_BITS{1'b0}}});
            side1_reg[0] <= {sel, d0, d1, d2};
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOT_LAT-1:1], s_valid};
        end
    end

    // ---------------- square root: r = floor(sqrt(A * 2^FRAC_BITS))
    logic [ROOT_W-1:0] root;

    rmq_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
        .aclk    (aclk),
        .en      (en),
        .rad_in  (rad_reg),
        .root_out(root)
    );

    for (genvar i = 0; i < ROOT_W; i++) begin : g_side1
        always_ff @(posedge aclk) begin
            if (en) begin
                side1_reg[i+1] <= side1_reg[i];
            end
        end
    end

    // ---------------- dividers
    rmq_pkg::sel_t        sel_a;
    logic signed [DW-1:0] da [3];
    logic [DW-1:0]        mag [3];
    logic [5:0]           sgn;

    always_comb begin
        sel_a = rmq_pkg::sel_t'(side1_reg[ROOT_W][SIDE1_W-1 -: 2]);
        da[0] = side1_reg[ROOT_W][3*DW-1 -: DW];
        da[1] = side1_reg[ROOT_W][2*DW-1 -: DW];
        da[2] = side1_reg[ROOT_W][DW-1:0];
        for (int k = 0; k < 3; k++) begin
            mag[k]       = da[k][DW-1] ? (DW'(0) - da[k]) : da[k];
            sgn[2*k+1]   = (da[k] > 0);
            sgn[2*k]     = da[k][DW-1];
        end
    end

    logic [DW-1:0] q [3];
    logic          ovf [3];

    for (genvar k = 0; k < 3; k++) begin : g_div
        rmq_div #(
            .DATA_WIDTH(DATA_WIDTH),
            .FRAC_BITS (FRAC_BITS),
            .ROOT_W    (ROOT_W)
        ) u_div (
            .aclk   (aclk),
            .en     (en),
            .mag_in (mag[k]),
            .r_in   (root),
            .q_out  (q[k]),
            .ovf_out(ovf[k])
        );
    end

    localparam int SIDE2_W = 2 + 6 + ROOT_W;
    logic [SIDE2_W-1:0] side2_reg [DIV_LAT+1];

    assign side2_reg[0] = {sel_a, sgn, root};
    for (genvar i = 0; i < DIV_LAT; i++) begin : g_side2
        always_ff @(posedge aclk) begin
            if (en) begin
                side2_reg[i+1] <= side2_reg[i];
            end
        end
    end

    // ---------------- final stage: signs, saturation, routing
    rmq_pkg::sel_t                sel_f;
    logic [5:0]                   sgn_f;
    logic [ROOT_W-1:0]            r_f;
    logic                         r_zero;
    logic [CW-1:0]                qr_wide;
    logic signed [DATA_WIDTH-1:0] quart;
    logic signed [DATA_WIDTH-1:0] part [3];
    logic [3:0]                   clip;
    logic signed [DATA_WIDTH-1:0] w_next, x_next, y_next, z_next;
    logic                         sat_next;
    logic [CW-1:0]                q_wide;

    always_comb begin
        sel_f   = rmq_pkg::sel_t'(side2_reg[DIV_LAT][SIDE2_W-1 -: 2]);
        sgn_f   = side2_reg[DIV_LAT][ROOT_W+5 -: 6];
        r_f     = side2_reg[DIV_LAT][ROOT_W-1:0];
        r_zero  = (r_f == '0);
        qr_wide = (CW'(r_f) + CW'(1)) >> 1;
        if (qr_wide > CW'(SMAX)) begin
            quart   = SMAX;
            clip[3] = 1'b1;
        end else begin
            quart   = qr_wide[DATA_WIDTH-1:0];
            clip[3] = r_zero;
        end
        for (int k = 0; k < 3; k++) begin
            q_wide = CW'(q[k]);
            if (r_zero) begin
                clip[k] = 1'b1;
                part[k] = sgn_f[2*k+1] ? SMAX : (sgn_f[2*k] ? SMIN : '0);
            end else if (sgn_f[2*k]) begin
                if (ovf[k] || q_wide > (CW'(SMAX) + CW'(1))) begin
                    clip[k] = 1'b1;
                    part[k] = SMIN;
                end else begin
                    clip[k] = 1'b0;
                    part[k] = DATA_WIDTH'(0) - q[k][DATA_WIDTH-1:0];
                end
            end else begin
                if (ovf[k] || q_wide > CW'(SMAX)) begin
                    clip[k] = 1'b1;
                    part[k] = SMAX;
                end else begin
                    clip[k] = 1'b0;
                    part[k] = q[k][DATA_WIDTH-1:0];
                end
            end
        end
        case (sel_f)
            rmq_pkg::SEL_TRACE: begin
                w_next = quart;   x_next = part[0]; y_next = part[1]; z_next = part[2];
            end
            rmq_pkg::SEL_X: begin
                w_next = part[0]; x_next = quart;   y_next = part[1]; z_next = part[2];
            end
            rmq_pkg::SEL_Y: begin
                w_next = part[0]; x_next = part[1]; y_next = quart;   z_next = part[2];
            end
            default: begin
                w_next = part[0]; x_next = part[1]; y_next = part[2]; z_next = quart;
            end
        endcase
        sat_next = |clip;
    end

    logic signed [DATA_WIDTH-1:0] w_reg, x_reg, y_reg, z_reg;
    logic                         sat_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg   <= w_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            sat_reg <= sat_next;
        end
    end

    assign m_valid     = vld_reg[TOT_LAT];
    assign m_quat_w    = w_reg;
    assign m_quat_x    = x_reg;
    assign m_quat_y    = y_reg;
    assign m_quat_z    = z_reg;
    assign m_saturated = sat_reg;

endmodule
